// File: src/eprm_pkg.sv
`default_nettype none
package eprm_pkg;

   localparam int MAX_ROWS = 4096;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COUNT_W  = $clog2(MAX_ROWS + 1);
   localparam int OFFSET_W = 33;
   localparam int ELEM_W   = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_QUERY   = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_DECREASING    = 3'd1,
      ST_PAST_END      = 3'd2,
      ST_FULL          = 3'd3,
      ST_NOT_ASCENDING = 3'd4
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [OFFSET_W-1:0] row_end;
      logic [ELEM_W-1:0]   element_id;
   } item_type;

endpackage
`default_nettype wire

// File: src/eprm_ram.sv
`default_nettype none
module eprm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: src/eprm_front.sv
`default_nettype none
module eprm_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic [eprm_pkg::OFFSET_W-1:0] req_row_end,
   input  wire logic [eprm_pkg::ELEM_W-1:0]   req_element_id,
   output logic                               q_valid,
   output eprm_pkg::item_type                 q_item,
   input  wire logic                          q_pop
);
   import eprm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_new;

   always_comb begin
      item_new.action     = action_type'(req_action);
      item_new.row_end    = req_row_end;
      item_new.element_id = req_element_id;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule
`default_nettype wire

// File: src/eprm_back.sv
`default_nettype none
module eprm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire eprm_pkg::item_type            q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_parent_valid,
   output logic [eprm_pkg::ROW_W-1:0]         rsp_parent_row,
   output logic [eprm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [eprm_pkg::OFFSET_W-1:0]      rsp_elem_total
);
   import eprm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN_WAIT,
      S_SCAN_CMP
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  row_count_ff, row_count_in;
   logic [OFFSET_W-1:0] total_ff, total_in;
   logic [ROW_W-1:0]    cursor_ff, cursor_in;
   logic [ROW_W-1:0]    last_parent_ff, last_parent_in;
   logic                last_parent_valid_ff, last_parent_valid_in;
   logic [ELEM_W-1:0]   prev_elem_ff, prev_elem_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                past_end_ff, past_end_in;
   logic [ELEM_W-1:0]   elem_ff, elem_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_pv_ff, rsp_pv_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_total_ff, rsp_total_in;

   logic                out_free;
   logic                res_load;
   logic                wr_en;
   logic [OFFSET_W-1:0] rd_data;
   logic                table_full;
   logic                new_parent;

   eprm_ram #(
      .WIDTH (OFFSET_W),
      .DEPTH (MAX_ROWS)
   ) u_row_end_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_count_ff[ROW_W-1:0]),
      .wr_data (q_item.row_end),
      .rd_addr (cursor_ff),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (row_count_ff == COUNT_W'(MAX_ROWS));
   assign new_parent = !last_parent_valid_ff || (cursor_ff != last_parent_ff);

   always_comb begin
      state_in             = state_ff;
      row_count_in         = row_count_ff;
      total_in             = total_ff;
      cursor_in            = cursor_ff;
      last_parent_in       = last_parent_ff;
      last_parent_valid_in = last_parent_valid_ff;
      prev_elem_in         = prev_elem_ff;
      prev_valid_in        = prev_valid_ff;
      past_end_in          = past_end_ff;
      elem_in              = elem_ff;
      q_pop                = 1'b0;
      wr_en                = 1'b0;
      res_load             = 1'b0;
      rsp_pv_in            = 1'b0;
      rsp_row_in           = '0;
      rsp_status_in        = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_item.action)
                  ACT_LOAD: begin
                     res_load = 1'b1;
                     if (table_full) begin
                        rsp_status_in = ST_FULL;
                     end else if (q_item.row_end < total_ff) begin
                        rsp_status_in = ST_DECREASING;
                     end else begin
                        wr_en        = 1'b1;
                        row_count_in = row_count_ff + 1'b1;
                        total_in     = q_item.row_end;
                     end
                  end
                  ACT_QUERY: begin
                     if (past_end_ff) begin
                        res_load      = 1'b1;
                        rsp_status_in = ST_PAST_END;
                     end else if (prev_valid_ff && (q_item.element_id < prev_elem_ff)) begin
                        res_load      = 1'b1;
                        rsp_status_in = ST_NOT_ASCENDING;
                     end else if ({1'b0, q_item.element_id} >= total_ff) begin
                        res_load      = 1'b1;
                        past_end_in   = 1'b1;
                        rsp_status_in = ST_PAST_END;
                     end else begin
                        prev_elem_in  = q_item.element_id;
                        prev_valid_in = 1'b1;
                        elem_in       = q_item.element_id;
                        state_in      = S_SCAN_WAIT;
                     end
                  end
                  ACT_RESTART, ACT_CLEAR: begin
                     res_load             = 1'b1;
                     cursor_in            = '0;
                     last_parent_in       = '0;
                     last_parent_valid_in = 1'b0;
                     prev_elem_in         = '0;
                     prev_valid_in        = 1'b0;
                     past_end_in          = 1'b0;
                     if (q_item.action == ACT_CLEAR) begin
                        row_count_in = '0;
                        total_in     = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN_WAIT: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_data <= {1'b0, elem_ff}) begin
               cursor_in = cursor_ff + 1'b1;
               state_in  = S_SCAN_WAIT;
            end else if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
               if (new_parent) begin
                  last_parent_in       = cursor_ff;
                  last_parent_valid_in = 1'b1;
                  rsp_pv_in            = 1'b1;
                  rsp_row_in           = cursor_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_total_in = total_in;
      rsp_valid_in = res_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         row_count_ff         <= '0;
         total_ff             <= '0;
         cursor_ff            <= '0;
         last_parent_ff       <= '0;
         last_parent_valid_ff <= 1'b0;
         prev_elem_ff         <= '0;
         prev_valid_ff        <= 1'b0;
         past_end_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         row_count_ff         <= row_count_in;
         total_ff             <= total_in;
         cursor_ff            <= cursor_in;
         last_parent_ff       <= last_parent_in;
         last_parent_valid_ff <= last_parent_valid_in;
         prev_elem_ff         <= prev_elem_in;
         prev_valid_ff        <= prev_valid_in;
         past_end_ff          <= past_end_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
      elem_ff <= elem_in;
      if (res_load) begin
         rsp_pv_ff     <= rsp_pv_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_status_ff <= rsp_status_in;
         rsp_total_ff  <= rsp_total_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parent_valid = rsp_pv_ff;
   assign rsp_parent_row   = rsp_row_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_elem_total   = rsp_total_ff;

endmodule
`default_nettype wire

// File: src/element_to_parent_row_mapper_top.sv
`default_nettype none
// Maps ascending element ids to parent rows through a table of cumulative row end offsets
// (up to 4096 rows, one block RAM with one registered read port). A front queue of two
// transactions absorbs requests while the back end works. Load, restart, clear and every
// rejected query finish in the idle state; an accepted query passes a RAM wait state and
// a compare state for each row it compares, since each row compare waits on one RAM read.
// A response register holds each result until it is taken, so the back end only stalls
// when a second result is ready while the first is still held.
module element_to_parent_row_mapper_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic [eprm_pkg::OFFSET_W-1:0] req_row_end,
   input  wire logic [eprm_pkg::ELEM_W-1:0]   req_element_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_parent_valid,
   output logic [eprm_pkg::ROW_W-1:0]         rsp_parent_row,
   output logic [eprm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [eprm_pkg::OFFSET_W-1:0]      rsp_elem_total
);
   import eprm_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   eprm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_row_end    (req_row_end),
      .req_element_id (req_element_id),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   eprm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parent_valid (rsp_parent_valid),
      .rsp_parent_row   (rsp_parent_row),
      .rsp_status       (rsp_status),
      .rsp_elem_total   (rsp_elem_total)
   );

endmodule
`default_nettype wire
